[hdl/size_class_block_allocator_unit_assert.svh]
// Assertion macros used by the allocator checker.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SCA_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SCA_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/sca_pkg.sv]
// Shared types and constants of the size class block allocator.
`timescale 1ns / 1ps

package sca_pkg;

  localparam int SCA_MAX_BLOCKS = 16;
  localparam int SCA_MAX_CLASS  = 512;

  localparam int MIN_CLASS     = 32;
  localparam int CLASS_LOG_MIN = 5;
  localparam int CLASS_LOG_TOP = 12;

  localparam int ADDR_W     = 16;
  localparam int REQ_W      = 10;
  localparam int GSIZE_W    = 10;
  localparam int STAT_W     = 3;
  localparam int OFF_W      = 17;
  localparam int CNT_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ADDR_SPAN  = 65536;

  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_OOM       = 3'd1;
  localparam logic [STAT_W-1:0] STAT_BAD_SIZE  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NULL_FREE = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOT_ALLOC = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BYTES = 2'd2;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [ADDR_W-1:0] RST_HEAP_BASE  = 16'd4096;
  localparam logic [ADDR_W-1:0] RST_HEAP_BYTES = 16'd32768;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } sca_state_t;

  // Search token walking a row of cells.
  typedef struct packed {
    logic              vld;
    logic              by_addr;
    logic              best_mode;
    logic              found;
    logic [ADDR_W-1:0] key_addr;
    logic [ADDR_W-1:0] best_addr;
  } sca_tok_t;

  // Update command broadcast to one row of cells.
  typedef struct packed {
    logic              rm_en;
    logic              app_en;
    logic [ADDR_W-1:0] app_addr;
  } sca_cmd_t;

endpackage

[hdl/sca_cell.sv]
// One list entry cell: holds a block, checks the passing search token, shifts and appends.
`timescale 1ns / 1ps

module sca_cell #(
  parameter int SZ_W  = 10,
  parameter int IDX_W = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [IDX_W-1:0]         idx_i,
  input  logic [SZ_W-1:0]          cls_i,
  input  sca_pkg::sca_tok_t        tok_i,
  input  logic [SZ_W-1:0]          bsize_i,
  input  logic [IDX_W-1:0]         bidx_i,
  output sca_pkg::sca_tok_t        tok_o,
  output logic [SZ_W-1:0]          bsize_o,
  output logic [IDX_W-1:0]         bidx_o,
  input  logic                     shift_i,
  input  logic                     nxt_v_i,
  input  logic [sca_pkg::ADDR_W-1:0] nxt_a_i,
  input  logic [SZ_W-1:0]          nxt_s_i,
  input  logic                     prv_v_i,
  input  logic                     app_en_i,
  input  logic [sca_pkg::ADDR_W-1:0] app_a_i,
  input  logic [SZ_W-1:0]          app_s_i,
  output logic                     v_o,
  output logic [sca_pkg::ADDR_W-1:0] a_o,
  output logic [SZ_W-1:0]          s_o
);
  import sca_pkg::*;

  logic              v_r, v_nxt;
  logic [ADDR_W-1:0] a_r, a_nxt;
  logic [SZ_W-1:0]   s_r, s_nxt;
  sca_tok_t          tok_r, tok_nxt;
  logic [SZ_W-1:0]   bsize_r, bsize_nxt;
  logic [IDX_W-1:0]  bidx_r, bidx_nxt;
  logic              hit, better, take;

  // Token check: address match, or a block large enough (strictly smaller wins in best fit).
  always_comb begin
    hit    = tok_i.vld && v_r &&
             (tok_i.by_addr ? (a_r == tok_i.key_addr) : (s_r >= cls_i));
    better = !tok_i.found || (!tok_i.by_addr && tok_i.best_mode && (s_r < bsize_i));
    take   = hit && better;

    tok_nxt       = tok_i;
    tok_nxt.found = tok_i.found || take;
    if (take) begin
      tok_nxt.best_addr = a_r;
    end
    bsize_nxt = take ? s_r : bsize_i;
    bidx_nxt  = take ? idx_i : bidx_i;
  end

  // Entry update: pull from the right neighbor on removal, load at the list tail on append.
  always_comb begin
    v_nxt = v_r;
    a_nxt = a_r;
    s_nxt = s_r;
    priority if (shift_i) begin
      v_nxt = nxt_v_i;
      a_nxt = nxt_a_i;
      s_nxt = nxt_s_i;
    end else if (app_en_i && !v_r && prv_v_i) begin
      v_nxt = 1'b1;
      a_nxt = app_a_i;
      s_nxt = app_s_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      tok_r <= '0;
    end else begin
      v_r   <= v_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    s_r     <= s_nxt;
    bsize_r <= bsize_nxt;
    bidx_r  <= bidx_nxt;
  end

  assign tok_o   = tok_r;
  assign bsize_o = bsize_r;
  assign bidx_o  = bidx_r;
  assign v_o     = v_r;
  assign a_o     = a_r;
  assign s_o     = s_r;

endmodule

[hdl/sca_ctrl.sv]
// Request sequencer: configuration, size class, token launch, bump pointer and result register.
`timescale 1ns / 1ps

module sca_ctrl #(
  parameter int MAX_BLOCKS = sca_pkg::SCA_MAX_BLOCKS,
  parameter int MAX_CLASS  = sca_pkg::SCA_MAX_CLASS,
  parameter int SZ_W       = 10,
  parameter int IDX_W      = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sca_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [sca_pkg::REQ_W-1:0]      in_req_size,
  input  logic [sca_pkg::ADDR_W-1:0]     in_block_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sca_pkg::STAT_W-1:0]     out_status,
  output logic [sca_pkg::ADDR_W-1:0]     out_grant_addr,
  output logic [sca_pkg::GSIZE_W-1:0]    out_grant_size,
  output sca_pkg::sca_tok_t             free_tok_o,
  output sca_pkg::sca_tok_t             used_tok_o,
  output logic [SZ_W-1:0]               cls_o,
  input  sca_pkg::sca_tok_t             free_tok_i,
  input  sca_pkg::sca_tok_t             used_tok_i,
  input  logic [SZ_W-1:0]               free_bsize_i,
  input  logic [SZ_W-1:0]               used_bsize_i,
  input  logic [IDX_W-1:0]              free_bidx_i,
  input  logic [IDX_W-1:0]              used_bidx_i,
  output sca_pkg::sca_cmd_t             free_cmd_o,
  output sca_pkg::sca_cmd_t             used_cmd_o,
  output logic [IDX_W-1:0]              free_rm_idx_o,
  output logic [IDX_W-1:0]              used_rm_idx_o,
  output logic [SZ_W-1:0]               free_app_size_o,
  output logic [SZ_W-1:0]               used_app_size_o
);
  import sca_pkg::*;

  sca_state_t        state_r, state_nxt;
  logic              fit_mode_r;
  logic [ADDR_W-1:0] heap_base_r, heap_bytes_r;
  logic [OFF_W-1:0]  break_r, break_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              launch_r;

  logic              act_r, bad_r;
  logic [ADDR_W-1:0] key_r;
  logic [SZ_W-1:0]   cls_r, cls_calc;
  logic              bad_calc;

  logic              f_found_r, u_found_r;
  logic [ADDR_W-1:0] f_addr_r;
  logic [SZ_W-1:0]   f_size_r, u_size_r;
  logic [IDX_W-1:0]  f_idx_r, u_idx_r;

  logic [OFF_W:0]    addr_sum, off_sum;
  logic [OFF_W+1:0]  end_sum;
  logic              bump_ok_r, bump_ok_nxt;
  logic [ADDR_W-1:0] bump_addr_r;

  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r, res_status;
  logic [ADDR_W-1:0]   out_addr_r, res_addr;
  logic [GSIZE_W-1:0]  out_size_r;
  logic [SZ_W-1:0]     res_size;
  logic                acc, done_fire, bump_take;

  // Round the request up to its class, capped at the largest class.
  always_comb begin : p_cls
    int c;
    c = MIN_CLASS;
    for (int p = CLASS_LOG_MIN; p < CLASS_LOG_TOP; p++) begin
      if (((1 << p) < MAX_CLASS) && (int'(in_req_size) > (1 << p))) begin
        c = 1 << (p + 1);
      end
    end
    if (c > MAX_CLASS) begin
      c = MAX_CLASS;
    end
    cls_calc = SZ_W'(c);
    bad_calc = (in_req_size == '0) || (int'(in_req_size) > MAX_CLASS);
  end

  // Bump check on the current break; registered, stable well before the result step.
  always_comb begin
    addr_sum    = {2'b00, heap_base_r} + {1'b0, break_r};
    off_sum     = {1'b0, break_r} + (OFF_W + 1)'(cls_r);
    end_sum     = {1'b0, addr_sum} + (OFF_W + 2)'(cls_r);
    bump_ok_nxt = (count_r < CNT_W'(MAX_BLOCKS)) &&
                  (off_sum <= (OFF_W + 1)'(heap_bytes_r)) &&
                  (end_sum <= (OFF_W + 2)'(ADDR_SPAN)) &&
                  (addr_sum != '0);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN: if (free_tok_i.vld) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, result and list commands.
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    acc        = in_valid && in_ready;
    done_fire  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
    res_status = STAT_OK;
    res_addr   = '0;
    res_size   = '0;
    bump_take  = 1'b0;
    free_cmd_o = '0;
    used_cmd_o = '0;
    free_rm_idx_o   = f_idx_r;
    used_rm_idx_o   = u_idx_r;
    free_app_size_o = u_size_r;
    used_app_size_o = f_size_r;
    free_cmd_o.app_addr = key_r;
    used_cmd_o.app_addr = f_addr_r;
    unique case (act_r)
      ACT_ALLOC: begin
        priority if (bad_r) begin
          res_status = STAT_BAD_SIZE;
        end else if (f_found_r) begin
          res_addr          = f_addr_r;
          res_size          = f_size_r;
          free_cmd_o.rm_en  = done_fire;
          used_cmd_o.app_en = done_fire;
        end else if (bump_ok_r) begin
          res_addr            = bump_addr_r;
          res_size            = cls_r;
          bump_take           = done_fire;
          used_cmd_o.app_en   = done_fire;
          used_cmd_o.app_addr = bump_addr_r;
          used_app_size_o     = cls_r;
        end else begin
          res_status = STAT_OOM;
        end
      end
      ACT_FREE: begin
        priority if (key_r == '0) begin
          res_status = STAT_NULL_FREE;
        end else if (u_found_r) begin
          res_size          = u_size_r;
          used_cmd_o.rm_en  = done_fire;
          free_cmd_o.app_en = done_fire;
        end else begin
          res_status = STAT_NOT_ALLOC;
        end
      end
      default: res_status = STAT_OK;
    endcase
    break_nxt = bump_take ? off_sum[OFF_W-1:0] : break_r;
    count_nxt = bump_take ? count_r + CNT_W'(1) : count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fit_mode_r   <= 1'b0;
      heap_base_r  <= RST_HEAP_BASE;
      heap_bytes_r <= RST_HEAP_BYTES;
      break_r      <= '0;
      count_r      <= '0;
      launch_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      break_r  <= break_nxt;
      count_r  <= count_nxt;
      launch_r <= acc;
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FIT_MODE:   fit_mode_r   <= cfg_wdata[0];
          CFG_HEAP_BASE:  heap_base_r  <= cfg_wdata;
          CFG_HEAP_BYTES: heap_bytes_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    bump_ok_r   <= bump_ok_nxt;
    bump_addr_r <= addr_sum[ADDR_W-1:0];
    if (acc) begin
      act_r <= in_action;
      bad_r <= bad_calc;
      key_r <= in_block_addr;
      cls_r <= cls_calc;
    end
    // Capture both search results as the tokens leave the rows.
    if ((state_r == ST_SCAN) && free_tok_i.vld) begin
      f_found_r <= free_tok_i.found;
      f_addr_r  <= free_tok_i.best_addr;
      f_size_r  <= free_bsize_i;
      f_idx_r   <= free_bidx_i;
      u_found_r <= used_tok_i.found;
      u_size_r  <= used_bsize_i;
      u_idx_r   <= used_bidx_i;
    end
    if (done_fire) begin
      out_status_r <= res_status;
      out_addr_r   <= res_addr;
      out_size_r   <= GSIZE_W'(res_size);
    end
  end

  always_comb begin
    free_tok_o           = '0;
    free_tok_o.vld       = launch_r;
    free_tok_o.best_mode = fit_mode_r;
    free_tok_o.key_addr  = key_r;
    used_tok_o           = '0;
    used_tok_o.vld       = launch_r;
    used_tok_o.by_addr   = 1'b1;
    used_tok_o.key_addr  = key_r;
  end

  assign cls_o          = cls_r;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_grant_addr = out_addr_r;
  assign out_grant_size = out_size_r;

endmodule

[hdl/size_class_block_allocator_unit.sv]
// Top level of the size class block allocator: sequencer and the free and allocated cell rows.
`timescale 1ns / 1ps

// Allocates blocks of 32 to MAX_CLASS bytes (power-of-two classes) from a heap window and frees
// them again. Free and allocated blocks each live in a row of MAX_BLOCKS cells kept in
// insertion order; a search token walks each row one cell per clock, and the next request is
// accepted only once the result of the last one has been registered; the result register lets
// that result wait while the next request is accepted.
// Registers: index 0 fit mode (0 first fit, 1 smallest adequate block), 1 heap base,
// 2 heap window size in bytes; write them only while no request is in flight.
module size_class_block_allocator_unit #(
  parameter int MAX_BLOCKS = sca_pkg::SCA_MAX_BLOCKS,
  parameter int MAX_CLASS  = sca_pkg::SCA_MAX_CLASS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sca_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic [sca_pkg::REQ_W-1:0]      in_req_size,
  input  logic [sca_pkg::ADDR_W-1:0]     in_block_addr,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sca_pkg::STAT_W-1:0]     out_status,
  output logic [sca_pkg::ADDR_W-1:0]     out_grant_addr,
  output logic [sca_pkg::GSIZE_W-1:0]    out_grant_size
);
  import sca_pkg::*;

  localparam int SZ_W  = $clog2(MAX_CLASS + 1);
  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  sca_tok_t          f_tok  [0:MAX_BLOCKS];
  logic [SZ_W-1:0]   f_bsz  [0:MAX_BLOCKS];
  logic [IDX_W-1:0]  f_bidx [0:MAX_BLOCKS];
  logic              f_v    [0:MAX_BLOCKS];
  logic [ADDR_W-1:0] f_a    [0:MAX_BLOCKS];
  logic [SZ_W-1:0]   f_s    [0:MAX_BLOCKS];
  logic              f_pv   [0:MAX_BLOCKS-1];

  sca_tok_t          u_tok  [0:MAX_BLOCKS];
  logic [SZ_W-1:0]   u_bsz  [0:MAX_BLOCKS];
  logic [IDX_W-1:0]  u_bidx [0:MAX_BLOCKS];
  logic              u_v    [0:MAX_BLOCKS];
  logic [ADDR_W-1:0] u_a    [0:MAX_BLOCKS];
  logic [SZ_W-1:0]   u_s    [0:MAX_BLOCKS];
  logic              u_pv   [0:MAX_BLOCKS-1];

  logic [SZ_W-1:0]   cls;
  sca_cmd_t          f_cmd, u_cmd;
  logic [IDX_W-1:0]  f_rm_idx, u_rm_idx;
  logic [SZ_W-1:0]   f_app_size, u_app_size;

  sca_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .MAX_CLASS  (MAX_CLASS),
    .SZ_W       (SZ_W),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_req_size     (in_req_size),
    .in_block_addr   (in_block_addr),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_grant_addr  (out_grant_addr),
    .out_grant_size  (out_grant_size),
    .free_tok_o      (f_tok[0]),
    .used_tok_o      (u_tok[0]),
    .cls_o           (cls),
    .free_tok_i      (f_tok[MAX_BLOCKS]),
    .used_tok_i      (u_tok[MAX_BLOCKS]),
    .free_bsize_i    (f_bsz[MAX_BLOCKS]),
    .used_bsize_i    (u_bsz[MAX_BLOCKS]),
    .free_bidx_i     (f_bidx[MAX_BLOCKS]),
    .used_bidx_i     (u_bidx[MAX_BLOCKS]),
    .free_cmd_o      (f_cmd),
    .used_cmd_o      (u_cmd),
    .free_rm_idx_o   (f_rm_idx),
    .used_rm_idx_o   (u_rm_idx),
    .free_app_size_o (f_app_size),
    .used_app_size_o (u_app_size)
  );

  // Row heads start with no candidate; row tails read as empty neighbors.
  assign f_bsz[0]           = '0;
  assign f_bidx[0]          = '0;
  assign u_bsz[0]           = '0;
  assign u_bidx[0]          = '0;
  assign f_v[MAX_BLOCKS]    = 1'b0;
  assign f_a[MAX_BLOCKS]    = '0;
  assign f_s[MAX_BLOCKS]    = '0;
  assign u_v[MAX_BLOCKS]    = 1'b0;
  assign u_a[MAX_BLOCKS]    = '0;
  assign u_s[MAX_BLOCKS]    = '0;

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign f_pv[k] = 1'b1;
      assign u_pv[k] = 1'b1;
    end else begin : g_body
      assign f_pv[k] = f_v[k-1];
      assign u_pv[k] = u_v[k-1];
    end

    sca_cell #(
      .SZ_W  (SZ_W),
      .IDX_W (IDX_W)
    ) u_free (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx_i    (IDX_W'(k)),
      .cls_i    (cls),
      .tok_i    (f_tok[k]),
      .bsize_i  (f_bsz[k]),
      .bidx_i   (f_bidx[k]),
      .tok_o    (f_tok[k+1]),
      .bsize_o  (f_bsz[k+1]),
      .bidx_o   (f_bidx[k+1]),
      .shift_i  (f_cmd.rm_en && (IDX_W'(k) >= f_rm_idx)),
      .nxt_v_i  (f_v[k+1]),
      .nxt_a_i  (f_a[k+1]),
      .nxt_s_i  (f_s[k+1]),
      .prv_v_i  (f_pv[k]),
      .app_en_i (f_cmd.app_en),
      .app_a_i  (f_cmd.app_addr),
      .app_s_i  (f_app_size),
      .v_o      (f_v[k]),
      .a_o      (f_a[k]),
      .s_o      (f_s[k])
    );

    sca_cell #(
      .SZ_W  (SZ_W),
      .IDX_W (IDX_W)
    ) u_used (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx_i    (IDX_W'(k)),
      .cls_i    (cls),
      .tok_i    (u_tok[k]),
      .bsize_i  (u_bsz[k]),
      .bidx_i   (u_bidx[k]),
      .tok_o    (u_tok[k+1]),
      .bsize_o  (u_bsz[k+1]),
      .bidx_o   (u_bidx[k+1]),
      .shift_i  (u_cmd.rm_en && (IDX_W'(k) >= u_rm_idx)),
      .nxt_v_i  (u_v[k+1]),
      .nxt_a_i  (u_a[k+1]),
      .nxt_s_i  (u_s[k+1]),
      .prv_v_i  (u_pv[k]),
      .app_en_i (u_cmd.app_en),
      .app_a_i  (u_cmd.app_addr),
      .app_s_i  (u_app_size),
      .v_o      (u_v[k]),
      .a_o      (u_a[k]),
      .s_o      (u_s[k])
    );
  end

endmodule

[hdl/sca_chk.sv]
// Port-level checker for the allocator, bound to the top level.
`timescale 1ns / 1ps
`include "size_class_block_allocator_unit_assert.svh"

module sca_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sca_pkg::STAT_W-1:0]  out_status,
  input logic [sca_pkg::ADDR_W-1:0]  out_grant_addr,
  input logic [sca_pkg::GSIZE_W-1:0] out_grant_size
);
  import sca_pkg::*;

  // Any error result carries neither address nor size.
  `SCA_AST_NOW(a_err_empty, out_valid && (out_status != STAT_OK), (out_grant_addr == '0) && (out_grant_size == '0), "error result with payload")

  // A granted block is always a whole number of minimum classes.
  `SCA_AST_NOW(a_grant_class, out_valid && (out_status == STAT_OK) && (out_grant_addr != '0), out_grant_size[4:0] == 5'd0, "granted size off class")

  // The block takes one request at a time.
  `SCA_AST_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request taken while busy")

  // A stalled result holds.
  `SCA_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_grant_addr) && $stable(out_grant_size), "stalled result changed")

endmodule

bind size_class_block_allocator_unit sca_chk u_sca_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_grant_addr (out_grant_addr),
  .out_grant_size (out_grant_size)
);
